// File: rtl/abfm_pkg.sv
// ---------------------------------------------------------------------------
// abfm_pkg
// shared constants, transaction types and helpers for the audio bridge fifo
// ---------------------------------------------------------------------------
package abfm_pkg;

    localparam int FIFO_DEPTH  = 8192;
    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_BITS  = 32;
    localparam int ADDR_BITS   = $clog2(FIFO_DEPTH);
    localparam int PTR_BITS    = ADDR_BITS + 1;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int QUOT_BITS   = PROD_BITS - GAIN_FRAC;
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(4096);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [PADDR_BITS-3:0] REG_IDX_GAIN = '0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] in_sample;
        logic                          block_last;
        logic                          driver_status;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_sample;
        logic                          accepted;
        logic [PTR_BITS-1:0]           fill_level;
        logic [SAMPLE_BITS-1:0]        peak_level;
        logic [COUNT_BITS-1:0]         overrun_total;
        logic [COUNT_BITS-1:0]         underrun_total;
        logic [COUNT_BITS-1:0]         capture_blocks;
        logic [COUNT_BITS-1:0]         playback_blocks;
    } t_out_item;

    // one accepted transaction as seen by the meters
    typedef struct packed {
        logic                          valid;
        logic                          pop;
        logic                          last;
        logic                          status;
        logic                          miss;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_meter_ev;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] peak;
        logic [COUNT_BITS-1:0]  overrun;
        logic [COUNT_BITS-1:0]  underrun;
        logic [COUNT_BITS-1:0]  capture;
        logic [COUNT_BITS-1:0]  playback;
    } t_meter_val;

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] cnt,
        input logic [1:0]            inc
    );
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, cnt} + (COUNT_BITS + 1)'(inc);
        return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    endfunction

endpackage

// File: rtl/abfm_ram.sv
// ---------------------------------------------------------------------------
// abfm_ram
// simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module abfm_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/abfm_gain.sv
// ---------------------------------------------------------------------------
// abfm_gain
// q4.12 gain stage: registered product, then round half up and saturate
// ---------------------------------------------------------------------------
module abfm_gain (
    input  logic                                    i_clk,
    input  logic                                    i_load,
    input  logic signed [abfm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [abfm_pkg::GAIN_BITS-1:0]          i_gain,
    output logic signed [abfm_pkg::SAMPLE_BITS-1:0] o_sample
);
    import abfm_pkg::*;

    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [PROD_BITS-1:0] n_prod;
    logic signed [PROD_BITS-1:0] rounded;
    logic signed [QUOT_BITS-1:0] quot;
    logic                        fits;

    assign n_prod = PROD_BITS'(i_sample) * PROD_BITS'($signed({1'b0, i_gain}));

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    // floor of (p + half) / 2^frac gives ties toward plus infinity
    assign rounded = r_prod + PROD_BITS'(1 << (GAIN_FRAC - 1));
    assign quot    = rounded[PROD_BITS-1:GAIN_FRAC];
    assign fits    = (quot[QUOT_BITS-1:SAMPLE_BITS-1] == '0)
                  || (quot[QUOT_BITS-1:SAMPLE_BITS-1] == '1);

    always_comb begin
        if (fits) begin
            o_sample = quot[SAMPLE_BITS-1:0];
        end else if (quot[QUOT_BITS-1]) begin
            o_sample = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end else begin
            o_sample = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end
    end

endmodule

// File: rtl/abfm_meters.sv
// ---------------------------------------------------------------------------
// abfm_meters
// capture peak tracking, block flags and saturating event counters
// ---------------------------------------------------------------------------
module abfm_meters (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  abfm_pkg::t_meter_ev    i_ev,
    output abfm_pkg::t_meter_val   o_val
);
    import abfm_pkg::*;

    logic [SAMPLE_BITS-1:0] r_run_peak, n_run_peak;
    logic [SAMPLE_BITS-1:0] r_peak,     n_peak;
    logic                   r_lost,     n_lost;
    logic                   r_short,    n_short;
    logic [COUNT_BITS-1:0]  r_over,     n_over;
    logic [COUNT_BITS-1:0]  r_under,    n_under;
    logic [COUNT_BITS-1:0]  r_cap,      n_cap;
    logic [COUNT_BITS-1:0]  r_play,     n_play;

    logic [SAMPLE_BITS-1:0] mag;
    logic [SAMPLE_BITS-1:0] peak_now;
    logic                   lost_now;
    logic                   short_now;
    logic [1:0]             under_inc;

    // most negative sample wraps to 2^(n-1), which is its exact magnitude
    assign mag = i_ev.sample[SAMPLE_BITS-1]
               ? SAMPLE_BITS'(~i_ev.sample) + SAMPLE_BITS'(1)
               : SAMPLE_BITS'(i_ev.sample);
    assign peak_now  = (mag > r_run_peak) ? mag : r_run_peak;
    assign lost_now  = r_lost | i_ev.miss;
    assign short_now = r_short | i_ev.miss;

    always_comb begin
        n_run_peak = r_run_peak;
        n_peak     = r_peak;
        n_lost     = r_lost;
        n_short    = r_short;
        n_over     = r_over;
        n_cap      = r_cap;
        n_play     = r_play;
        under_inc  = 2'd0;
        if (i_ev.valid && !i_ev.pop) begin
            if (i_ev.last) begin
                n_peak     = peak_now;
                n_run_peak = '0;
                n_lost     = 1'b0;
                n_over     = sat_add(r_over, {1'b0, lost_now});
                n_cap      = sat_add(r_cap, 2'd1);
                under_inc  = {1'b0, i_ev.status};
            end else begin
                n_run_peak = peak_now;
                n_lost     = lost_now;
            end
        end else if (i_ev.valid && i_ev.pop) begin
            if (i_ev.last) begin
                n_short   = 1'b0;
                n_play    = sat_add(r_play, 2'd1);
                under_inc = {1'b0, i_ev.status} + {1'b0, short_now};
            end else begin
                n_short = short_now;
            end
        end
        n_under = sat_add(r_under, under_inc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_peak <= '0;
            r_peak     <= '0;
            r_lost     <= 1'b0;
            r_short    <= 1'b0;
            r_over     <= '0;
            r_under    <= '0;
            r_cap      <= '0;
            r_play     <= '0;
        end else begin
            r_run_peak <= n_run_peak;
            r_peak     <= n_peak;
            r_lost     <= n_lost;
            r_short    <= n_short;
            r_over     <= n_over;
            r_under    <= n_under;
            r_cap      <= n_cap;
            r_play     <= n_play;
        end
    end

    assign o_val.peak     = r_peak;
    assign o_val.overrun  = r_over;
    assign o_val.underrun = r_under;
    assign o_val.capture  = r_cap;
    assign o_val.playback = r_play;

endmodule

// File: rtl/audio_bridge_fifo_with_meters.sv
// ---------------------------------------------------------------------------
// audio_bridge_fifo_with_meters
// sample fifo between capture and playback with gain, peak and event meters
//
//   channel   signals                              transaction
//   command   start, busy, i_cmd                   start && !busy
//   result    o_done, o_result                     o_done (one cycle)
//   config    psel penable pwrite paddr pwdata     psel && penable && pwrite
//             prdata pready
//
// push and empty pop: the strobe follows state ST_DONE and the result register
// pop with data: the strobe follows the registered ram read (ST_READ), the
// registered gain product (ST_ROUND) and the result register; busy holds off
// a new command until then, and the next start is taken at the edge that takes the strobe
// reset clears pointers, meters and gain; store contents are undefined,
// no clearing pass
// results cannot be stalled; busy alone throttles the command side
// ---------------------------------------------------------------------------
module audio_bridge_fifo_with_meters (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  abfm_pkg::t_in_item                    i_cmd,
    output logic                                  o_done,
    output abfm_pkg::t_out_item                   o_result,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [abfm_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [abfm_pkg::PDATA_BITS-1:0]       pwdata,
    output logic [abfm_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                  pready
);
    import abfm_pkg::*;

    t_state                  r_state, n_state;
    logic [PTR_BITS-1:0]     r_wr_ptr, r_rd_ptr;
    logic [GAIN_BITS-1:0]    r_gain;
    logic                    r_ok;
    logic                    r_done;
    t_out_item               r_result;

    logic                    accept;
    logic                    is_pop;
    logic [PTR_BITS-1:0]     fill;
    logic                    full;
    logic                    empty;
    logic                    wr_en;
    logic                    rd_en;
    logic                    gain_load;
    logic                    result_load;
    logic [SAMPLE_BITS-1:0]  rd_data;
    logic signed [SAMPLE_BITS-1:0] gained;
    logic                    cfg_wr;
    logic [PADDR_BITS-3:0]   reg_idx;
    t_meter_ev               meter_ev;
    t_meter_val              meter_val;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == REG_IDX_GAIN) ? PDATA_BITS'(r_gain) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (cfg_wr && reg_idx == REG_IDX_GAIN) begin
            r_gain <= pwdata[GAIN_BITS-1:0];
        end
    end

    // pointers run modulo twice the depth so full and empty differ
    assign fill   = r_wr_ptr - r_rd_ptr;
    assign full   = (fill == PTR_BITS'(FIFO_DEPTH));
    assign empty  = (fill == '0);
    assign accept = start && !busy;
    assign is_pop = (i_cmd.op == OP_POP);
    assign wr_en  = accept && !is_pop && !full;
    assign rd_en  = accept && is_pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
        end
    end

    abfm_ram #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wr_ptr[ADDR_BITS-1:0]),
        .i_wr_data (i_cmd.in_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr[ADDR_BITS-1:0]),
        .o_rd_data (rd_data)
    );

    abfm_gain u_gain (
        .i_clk    (i_clk),
        .i_load   (gain_load),
        .i_sample ($signed(rd_data)),
        .i_gain   (r_gain),
        .o_sample (gained)
    );

    assign meter_ev.valid  = accept;
    assign meter_ev.pop    = is_pop;
    assign meter_ev.last   = i_cmd.block_last;
    assign meter_ev.status = i_cmd.driver_status;
    assign meter_ev.miss   = is_pop ? empty : full;
    assign meter_ev.sample = i_cmd.in_sample;

    abfm_meters u_meters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ev    (meter_ev),
        .o_val   (meter_val)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        busy        = 1'b1;
        gain_load   = 1'b0;
        result_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (accept) begin
                    n_state = rd_en ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                gain_load = 1'b1;
                n_state   = ST_ROUND;
            end
            ST_ROUND: begin
                result_load = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_DONE: begin
                result_load = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok <= wr_en || rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result_load) begin
            r_result.out_sample      <= (r_state == ST_ROUND) ? gained : '0;
            r_result.accepted        <= r_ok;
            r_result.fill_level      <= fill;
            r_result.peak_level      <= meter_val.peak;
            r_result.overrun_total   <= meter_val.overrun;
            r_result.underrun_total  <= meter_val.underrun;
            r_result.capture_blocks  <= meter_val.capture;
            r_result.playback_blocks <= meter_val.playback;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= result_load;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= PTR_BITS'(FIFO_DEPTH))
        else $error("fifo fill beyond depth");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.accepted) |-> (o_result.out_sample == '0))
        else $error("dropped or empty transaction returned a nonzero sample");
`endif

endmodule

// File: sim/audio_bridge_fifo_with_meters_tb.sv
// ---------------------------------------------------------------------------
// audio_bridge_fifo_with_meters_tb
// checks every result of the sample fifo against a cycle-free predictor of
// the store, gain rounding, peak meter and event counters; directed corners,
// then random capture and playback blocks under several gains and sender
// idle patterns
// ---------------------------------------------------------------------------
module audio_bridge_fifo_with_meters_tb;

    import abfm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [PADDR_BITS-1:0] GAIN_ADDR = {REG_IDX_GAIN, 2'b00};

    // -----------------------------------------------------------------------
    // predictor plus store of expected results
    // -----------------------------------------------------------------------
    class bridge_scoreboard;
        logic [SAMPLE_BITS-1:0] sample_mem [FIFO_DEPTH];
        logic [PTR_BITS-1:0]    wr_ptr;
        logic [PTR_BITS-1:0]    rd_ptr;
        logic [SAMPLE_BITS-1:0] run_peak;
        logic [SAMPLE_BITS-1:0] held_peak;
        logic                   lost_in_block;
        logic                   short_in_block;
        logic [COUNT_BITS-1:0]  overrun_cnt;
        logic [COUNT_BITS-1:0]  underrun_cnt;
        logic [COUNT_BITS-1:0]  capture_cnt;
        logic [COUNT_BITS-1:0]  playback_cnt;
        logic [GAIN_BITS-1:0]   gain;
        t_out_item              pending [$];
        int                     fail_count;

        function new();
            wr_ptr         = '0;
            rd_ptr         = '0;
            run_peak       = '0;
            held_peak      = '0;
            lost_in_block  = 1'b0;
            short_in_block = 1'b0;
            overrun_cnt    = '0;
            underrun_cnt   = '0;
            capture_cnt    = '0;
            playback_cnt   = '0;
            gain           = GAIN_RESET;
            fail_count     = 0;
        endfunction

        function logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        // q4.12 gain, round half up, clamp to the sample range
        function logic signed [SAMPLE_BITS-1:0] gained(logic signed [SAMPLE_BITS-1:0] s);
            longint prod;
            longint q;
            prod = longint'(s) * longint'(gain);
            q = (prod + 2048) >>> GAIN_FRAC;
            if (q > longint'(8388607))
                q = 8388607;
            if (q < -longint'(8388608))
                q = -8388608;
            return SAMPLE_BITS'(q);
        endfunction

        function void note_command(t_in_item c);
            t_out_item              e;
            logic [SAMPLE_BITS-1:0] mag;
            logic [PTR_BITS-1:0]    fill;
            e = '0;
            fill = wr_ptr - rd_ptr;
            if (c.op == OP_PUSH) begin
                mag = c.in_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-c.in_sample)
                                                 : SAMPLE_BITS'(c.in_sample);
                if (mag > run_peak)
                    run_peak = mag;
                if (fill < PTR_BITS'(FIFO_DEPTH)) begin
                    sample_mem[wr_ptr[ADDR_BITS-1:0]] = c.in_sample;
                    wr_ptr = wr_ptr + 1'b1;
                    e.accepted = 1'b1;
                end else begin
                    lost_in_block = 1'b1;
                end
                if (c.block_last) begin
                    held_peak = run_peak;
                    run_peak = '0;
                    if (lost_in_block)
                        overrun_cnt = sat_inc(overrun_cnt);
                    lost_in_block = 1'b0;
                    capture_cnt = sat_inc(capture_cnt);
                    if (c.driver_status)
                        underrun_cnt = sat_inc(underrun_cnt);
                end
            end else begin
                if (fill != '0) begin
                    e.out_sample = gained(sample_mem[rd_ptr[ADDR_BITS-1:0]]);
                    rd_ptr = rd_ptr + 1'b1;
                    e.accepted = 1'b1;
                end else begin
                    short_in_block = 1'b1;
                end
                if (c.block_last) begin
                    if (c.driver_status)
                        underrun_cnt = sat_inc(underrun_cnt);
                    if (short_in_block)
                        underrun_cnt = sat_inc(underrun_cnt);
                    short_in_block = 1'b0;
                    playback_cnt = sat_inc(playback_cnt);
                end
            end
            e.fill_level      = wr_ptr - rd_ptr;
            e.peak_level      = held_peak;
            e.overrun_total   = overrun_cnt;
            e.underrun_total  = underrun_cnt;
            e.capture_blocks  = capture_cnt;
            e.playback_blocks = playback_cnt;
            pending.push_back(e);
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(t_out_item r);
            t_out_item e;
            if (pending.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                fail_count++;
                return;
            end
            e = pending.pop_front();
            check_field("out_sample", longint'(e.out_sample), longint'(r.out_sample));
            check_field("accepted", longint'(e.accepted), longint'(r.accepted));
            check_field("fill_level", longint'(e.fill_level), longint'(r.fill_level));
            check_field("peak_level", longint'(e.peak_level), longint'(r.peak_level));
            check_field("overrun_total", longint'(e.overrun_total),
                        longint'(r.overrun_total));
            check_field("underrun_total", longint'(e.underrun_total),
                        longint'(r.underrun_total));
            check_field("capture_blocks", longint'(e.capture_blocks),
                        longint'(r.capture_blocks));
            check_field("playback_blocks", longint'(e.playback_blocks),
                        longint'(r.playback_blocks));
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // block and clock
    // -----------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    t_in_item              i_cmd   = '0;
    logic                  o_done;
    t_out_item             o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_BITS-1:0] paddr   = '0;
    logic [PDATA_BITS-1:0] pwdata  = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    bridge_scoreboard sb = new();
    int               cycle_count = 0;
    int               idle_pct = 0;

    audio_bridge_fifo_with_meters dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // values read here are the ones from before the edge
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else if (i_rst_n) begin
            if (start && !busy)
                sb.note_command(i_cmd);
            if (o_done)
                sb.check_result(o_result);
        end
    end

    // -----------------------------------------------------------------------
    // drivers
    // -----------------------------------------------------------------------
    task automatic send(input logic op, input logic signed [SAMPLE_BITS-1:0] smp,
                        input logic last, input logic stat);
        t_in_item it;
        it.op            = op;
        it.in_sample     = smp;
        it.block_last    = last;
        it.driver_status = stat;
        start <= 1'b1;
        i_cmd <= it;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    // gain write, then read it back
    task automatic write_gain(input logic [GAIN_BITS-1:0] g);
        logic [PDATA_BITS-1:0] rd;
        wait_drained();
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GAIN_ADDR;
        pwdata  <= PDATA_BITS'(g);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.gain = g;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.check_field("playback_gain", longint'(PDATA_BITS'(g)), longint'(rd));
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return 24'sh7fffff;
            1:       return 24'sh800000;
            2:       return '0;
            3:       return '1;
            4:       return SAMPLE_BITS'($urandom_range(510)) - 24'sd255;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // status on a block end is rare trouble; elsewhere it must be ignored
    function automatic logic rand_status(input logic last);
        return last ? ($urandom_range(7) == 0) : 1'($urandom_range(1));
    endfunction

    task automatic random_traffic(input int count);
        int done_items;
        int kind;
        int len;
        done_items = 0;
        while (done_items < count) begin
            kind = $urandom_range(99);
            len  = $urandom_range(24, 1);
            if (kind < 42) begin
                for (int k = 0; k < len; k++)
                    send(OP_PUSH, rand_sample(), k == len - 1, rand_status(k == len - 1));
            end else if (kind < 84) begin
                for (int k = 0; k < len; k++)
                    send(OP_POP, rand_sample(), k == len - 1, rand_status(k == len - 1));
            end else begin
                len = $urandom_range(6, 1);
                for (int k = 0; k < len; k++)
                    send(1'($urandom_range(1)), rand_sample(), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
            end
            done_items += len;
            if ($urandom_range(99) < 2)
                wait_drained();
        end
    endtask

    // -----------------------------------------------------------------------
    // sequence
    // -----------------------------------------------------------------------
    logic [GAIN_BITS-1:0] phase_gain [5] = '{16'h0001, 16'hffff, GAIN_RESET, 16'h0000, 16'h0800};

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unity gain: empty pop, extremes, status away from a block end
        send(OP_POP, '0, 1'b1, 1'b1);
        send(OP_PUSH, 24'sh7fffff, 1'b0, 1'b1);
        send(OP_PUSH, 24'sh800000, 1'b0, 1'b0);
        send(OP_PUSH, '0, 1'b0, 1'b1);
        send(OP_PUSH, '1, 1'b1, 1'b0);
        send(OP_POP, '0, 1'b0, 1'b1);
        send(OP_POP, '0, 1'b0, 1'b0);
        send(OP_POP, '0, 1'b0, 1'b0);
        send(OP_POP, '0, 1'b1, 1'b1);
        send(OP_POP, '0, 1'b0, 1'b0);
        send(OP_PUSH, 24'sd5, 1'b1, 1'b1);
        send(OP_POP, '0, 1'b1, 1'b0);

        // full scale gain saturates both ways
        write_gain(16'hffff);
        send(OP_PUSH, 24'sh7fffff, 1'b0, 1'b0);
        send(OP_PUSH, 24'sh800000, 1'b0, 1'b0);
        send(OP_PUSH, 24'sd1, 1'b1, 1'b0);
        send(OP_POP, '0, 1'b0, 1'b0);
        send(OP_POP, '0, 1'b0, 1'b0);
        send(OP_POP, '0, 1'b1, 1'b0);

        // half gain lands on rounding ties
        write_gain(16'h0800);
        send(OP_PUSH, 24'sd1, 1'b0, 1'b0);
        send(OP_PUSH, -24'sd3, 1'b1, 1'b0);
        send(OP_POP, '0, 1'b0, 1'b0);
        send(OP_POP, '0, 1'b1, 1'b0);

        write_gain(16'h0000);
        send(OP_PUSH, 24'sd12345, 1'b1, 1'b0);
        send(OP_POP, '0, 1'b1, 1'b0);

        for (int p = 0; p < 5; p++) begin
            write_gain((p == 3) ? 16'($urandom_range(65535)) : phase_gain[p]);
            case (p % 4)
                1:       idle_pct = 65;
                3:       idle_pct = 29;
                default: idle_pct = 0;
            endcase
            random_traffic(350);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
rtl/abfm_pkg.sv
rtl/abfm_ram.sv
rtl/abfm_gain.sv
rtl/abfm_meters.sv
rtl/audio_bridge_fifo_with_meters.sv
sim/audio_bridge_fifo_with_meters_tb.sv
